/* hdl/flhc_pkg.sv */
// flhc_pkg: command, fan level and register codes, configuration and
// evaluation structs shared by the fan level hysteresis controller.
// No dependencies.
package flhc_pkg;

  typedef enum logic [2:0] {
    CMD_GOOD  = 3'd0,
    CMD_FAIL  = 3'd1,
    CMD_EVAL  = 3'd2,
    CMD_QUERY = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    FAN_OFF  = 2'd0,
    FAN_LOW  = 2'd1,
    FAN_FULL = 2'd2
  } fan_lvl_t;

  typedef enum logic [2:0] {
    REG_OFF_TO_LOW  = 3'd0,
    REG_LOW_TO_HIGH = 3'd1,
    REG_HIGH_TO_LOW = 3'd2,
    REG_LOW_TO_OFF  = 3'd3,
    REG_CRITICAL    = 3'd4,
    REG_STALE_LIMIT = 3'd5,
    REG_THIRD_OFFS  = 3'd6,
    REG_CRIT_ONLY   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [7:0] off_to_low;
    logic signed [7:0] low_to_high;
    logic signed [7:0] high_to_low;
    logic signed [7:0] low_to_off;
    logic signed [7:0] critical;
    logic [3:0]        stale_limit;
    logic signed [6:0] third_offset;
    logic              critical_only;
  } cfg_t;

  typedef struct packed {
    fan_lvl_t level;
    logic     changed;
  } eval_res_t;

  localparam logic signed [7:0] TEMP_MAX = 8'sd127;
  localparam logic signed [7:0] TEMP_MIN = -8'sd128;

  localparam logic signed [7:0] RST_OFF_TO_LOW  = 8'sd42;
  localparam logic signed [7:0] RST_LOW_TO_HIGH = 8'sd46;
  localparam logic signed [7:0] RST_HIGH_TO_LOW = 8'sd42;
  localparam logic signed [7:0] RST_LOW_TO_OFF  = 8'sd38;
  localparam logic signed [7:0] RST_CRITICAL    = 8'sd75;
  localparam logic [3:0]        RST_STALE_LIMIT = 4'd3;
  localparam logic signed [6:0] RST_THIRD_OFFS  = -7'sd20;
  localparam logic [3:0]        RST_FAIL_COUNT  = 4'd3;

  // margin below which critical-only mode keeps the current level
  localparam logic signed [9:0] MARGIN_SAFE     = 10'sd10;
  // sensor that gets the configurable offset
  localparam int                OFFSET_SENSOR   = 2;

endpackage

/* hdl/flhc_eval.sv */
// flhc_eval: combinational fan evaluation - hottest live sensor, critical
// margin and the off/low/high hysteresis step.
// Depends on flhc_pkg.
module flhc_eval import flhc_pkg::*; #(
  parameter int NUM_SENSORS = 3
) (
  input  cfg_t                    cfg,
  input  logic signed [7:0]       cur [NUM_SENSORS],
  input  logic [NUM_SENSORS-1:0]  stale,
  input  fan_lvl_t                level_in,
  output eval_res_t               res
);

  always_comb begin
    logic              any_live;
    logic              stale_seen;
    logic              crit_hit;
    logic              near_crit;
    logic signed [9:0] best;
    logic signed [9:0] t;
    logic signed [9:0] diff;
    logic signed [9:0] crit_w;
    logic signed [9:0] offs_w;
    logic signed [9:0] ol_w;
    logic signed [9:0] lh_w;
    logic signed [9:0] hl_w;
    logic signed [9:0] lo_w;
    fan_lvl_t          lvl;

    any_live   = 1'b0;
    stale_seen = 1'b0;
    crit_hit   = 1'b0;
    near_crit  = 1'b0;
    best       = '0;
    t          = '0;
    diff       = '0;
    crit_w     = {{2{cfg.critical[7]}}, cfg.critical};
    offs_w     = {{3{cfg.third_offset[6]}}, cfg.third_offset};
    ol_w       = {{2{cfg.off_to_low[7]}}, cfg.off_to_low};
    lh_w       = {{2{cfg.low_to_high[7]}}, cfg.low_to_high};
    hl_w       = {{2{cfg.high_to_low[7]}}, cfg.high_to_low};
    lo_w       = {{2{cfg.low_to_off[7]}}, cfg.low_to_off};

    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (stale[i]) begin
        stale_seen = 1'b1;
      end else begin
        diff = crit_w - {{2{cur[i][7]}}, cur[i]};
        if (diff <= 10'sd0) crit_hit = 1'b1;
        if (diff < MARGIN_SAFE) near_crit = 1'b1;
        t = {{2{cur[i][7]}}, cur[i]};
        if (i == OFFSET_SENSOR) t = t + offs_w;
        if (!any_live || t > best) best = t;
        any_live = 1'b1;
      end
    end

    lvl = level_in;
    if (any_live) begin
      if (!cfg.critical_only) begin
        if (lvl == FAN_FULL && best <= hl_w) lvl = FAN_LOW;
        if (lvl == FAN_LOW && best <= lo_w) lvl = FAN_OFF;
        if (lvl == FAN_OFF && best >= ol_w) lvl = FAN_LOW;
        if (lvl == FAN_LOW && best >= lh_w) lvl = FAN_FULL;
      end else if (!near_crit) begin
        lvl = FAN_OFF;
      end
      if (stale_seen && lvl == FAN_OFF) lvl = FAN_LOW;
      if (crit_hit) lvl = FAN_FULL;
    end else begin
      lvl = FAN_FULL;
    end

    res.level   = lvl;
    res.changed = (lvl != level_in);
  end

endmodule

/* hdl/fan_level_hysteresis_controller.sv */
// fan_level_hysteresis_controller: top level - input register, per-sensor
// state, configuration registers and result register.
// Depends on flhc_pkg and flhc_eval.
//
// channel  direction  handshake             payload
// in_      input      in_valid / in_stall   cmd, sensor_index, reading
// out_     output     out_valid / out_stall fan_level, fan_changed, ok, temps
// cfg_     input      cfg_valid / cfg_ready index (3 bit), data (8 bit)
//
// One transaction per cycle sustained while out_stall is low; the input
// register takes it on acceptance and the evaluation logic then loads the
// result register from it, so the result is offered after the input and
// result registers. The sensor state is updated as the result register loads.
// Synchronous active-low reset: all sensors stale, fan high, min/max cleared.
// A stall on the result side holds the result register and backs up into
// in_stall only once the input register is also full.
module fan_level_hysteresis_controller import flhc_pkg::*; #(
  parameter int NUM_SENSORS = 3
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_cmd,
  input  logic [2:0]        in_sensor_index,
  input  logic signed [7:0] in_reading,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_fan_level,
  output logic              out_fan_changed,
  output logic              out_ok,
  output logic signed [7:0] out_current_temp,
  output logic signed [7:0] out_min_temp,
  output logic signed [7:0] out_max_temp,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  localparam int IDX_W = $clog2(NUM_SENSORS);

  // input stage
  logic              v1_r, v1_nxt;
  cmd_t              cmd_r;
  logic [2:0]        idx_r;
  logic signed [7:0] rd_r;

  // result stage
  logic              out_valid_r, out_valid_nxt;
  fan_lvl_t          res_lvl_r, res_lvl_nxt;
  logic              res_chg_r, res_chg_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic signed [7:0] res_cur_r, res_cur_nxt;
  logic signed [7:0] res_min_r, res_min_nxt;
  logic signed [7:0] res_max_r, res_max_nxt;

  // block state
  cfg_t              cfg_r;
  fan_lvl_t          fan_r, fan_nxt;
  logic signed [7:0] cur_r [NUM_SENSORS];
  logic signed [7:0] min_r [NUM_SENSORS];
  logic signed [7:0] max_r [NUM_SENSORS];
  logic [3:0]        fail_r [NUM_SENSORS];

  logic                   adv;
  logic                   fire;
  logic                   in_fire;
  logic                   idx_ok;
  logic [IDX_W-1:0]       idx_sel;
  logic [NUM_SENSORS-1:0] stale;
  logic signed [7:0]      sel_cur;
  logic signed [7:0]      sel_min;
  logic signed [7:0]      sel_max;
  logic [3:0]             sel_fail;
  logic                   sel_stale;
  eval_res_t              ev;

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = v1_r && adv;
  assign in_stall = v1_r && !adv;
  assign in_fire  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign idx_ok  = ({1'b0, idx_r} < 4'(NUM_SENSORS));
  assign idx_sel = idx_r[IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      stale[i] = (fail_r[i] >= cfg_r.stale_limit);
    end
  end

  // out-of-range indexes are masked by idx_ok wherever these are used
  assign sel_cur   = cur_r[idx_sel];
  assign sel_min   = min_r[idx_sel];
  assign sel_max   = max_r[idx_sel];
  assign sel_fail  = fail_r[idx_sel];
  assign sel_stale = (sel_fail >= cfg_r.stale_limit);

  flhc_eval #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_eval (
    .cfg      (cfg_r),
    .cur      (cur_r),
    .stale    (stale),
    .level_in (fan_r),
    .res      (ev)
  );

  always_comb begin
    v1_nxt = v1_r;
    if (in_fire) begin
      v1_nxt = 1'b1;
    end else if (fire) begin
      v1_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    fan_nxt     = fan_r;
    res_chg_nxt = 1'b0;
    res_ok_nxt  = 1'b0;
    res_cur_nxt = '0;
    res_min_nxt = '0;
    res_max_nxt = '0;
    case (cmd_r)
      CMD_EVAL: begin
        fan_nxt     = ev.level;
        res_chg_nxt = ev.changed;
      end
      CMD_QUERY: begin
        if (idx_ok && !sel_stale) begin
          res_ok_nxt  = 1'b1;
          res_cur_nxt = sel_cur;
          res_min_nxt = sel_min;
          res_max_nxt = sel_max;
        end
      end
      CMD_CLEAR: begin
        res_ok_nxt = idx_ok;
      end
      default: ;
    endcase
    res_lvl_nxt = fan_nxt;
  end

  // control and reset-valued state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      fan_r       <= FAN_FULL;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        min_r[i]  <= TEMP_MAX;
        max_r[i]  <= TEMP_MIN;
        fail_r[i] <= RST_FAIL_COUNT;
      end
    end else begin
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        fan_r <= fan_nxt;
        if (idx_ok) begin
          case (cmd_r)
            CMD_GOOD: begin
              if (rd_r < sel_min) min_r[idx_sel] <= rd_r;
              if (rd_r > sel_max) max_r[idx_sel] <= rd_r;
              fail_r[idx_sel] <= '0;
            end
            CMD_FAIL: begin
              // count stops at the limit
              if (!sel_stale) fail_r[idx_sel] <= sel_fail + 4'd1;
            end
            CMD_CLEAR: begin
              if (sel_stale) begin
                min_r[idx_sel] <= TEMP_MAX;
                max_r[idx_sel] <= TEMP_MIN;
              end else begin
                min_r[idx_sel] <= sel_cur;
                max_r[idx_sel] <= sel_cur;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // payload registers and the never-reset current readings
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cmd_t'(in_cmd);
      idx_r <= in_sensor_index;
      rd_r  <= in_reading;
    end
    if (fire) begin
      res_lvl_r <= res_lvl_nxt;
      res_chg_r <= res_chg_nxt;
      res_ok_r  <= res_ok_nxt;
      res_cur_r <= res_cur_nxt;
      res_min_r <= res_min_nxt;
      res_max_r <= res_max_nxt;
      if (cmd_r == CMD_GOOD && idx_ok) cur_r[idx_sel] <= rd_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.off_to_low    <= RST_OFF_TO_LOW;
      cfg_r.low_to_high   <= RST_LOW_TO_HIGH;
      cfg_r.high_to_low   <= RST_HIGH_TO_LOW;
      cfg_r.low_to_off    <= RST_LOW_TO_OFF;
      cfg_r.critical      <= RST_CRITICAL;
      cfg_r.stale_limit   <= RST_STALE_LIMIT;
      cfg_r.third_offset  <= RST_THIRD_OFFS;
      cfg_r.critical_only <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OFF_TO_LOW:  cfg_r.off_to_low    <= cfg_data;
        REG_LOW_TO_HIGH: cfg_r.low_to_high   <= cfg_data;
        REG_HIGH_TO_LOW: cfg_r.high_to_low   <= cfg_data;
        REG_LOW_TO_OFF:  cfg_r.low_to_off    <= cfg_data;
        REG_CRITICAL:    cfg_r.critical      <= cfg_data;
        REG_STALE_LIMIT: cfg_r.stale_limit   <= cfg_data[3:0];
        REG_THIRD_OFFS:  cfg_r.third_offset  <= cfg_data[6:0];
        REG_CRIT_ONLY:   cfg_r.critical_only <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fan_level    = res_lvl_r;
  assign out_fan_changed  = res_chg_r;
  assign out_ok           = res_ok_r;
  assign out_current_temp = res_cur_r;
  assign out_min_temp     = res_min_r;
  assign out_max_temp     = res_max_r;

  // a stalled input always means the input register holds a transaction
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r)
    else $error("in_stall raised with empty input register");

  // a processed transaction always lands in the result register
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed transaction produced no result");

  // a reported change really moves the stored fan level
  a_change_moves_level: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd_r == CMD_EVAL && ev.changed) |=> (fan_r != $past(fan_r)))
    else $error("fan change flagged without level change");

  // only evaluations move the fan level
  a_level_only_on_eval: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && cmd_r == CMD_EVAL) |=> $stable(fan_r))
    else $error("fan level moved outside an evaluation");

endmodule
